// ===== rtl/fqpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fqpc_pkg
// Shared types and constants for the fifo queue with peek and match count.
// ----------------------------------------------------------------------------
package fqpc_pkg;

  // default sizing of the queue
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  // fixed field widths of the command and response transactions
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 5;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_GET   = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_e;

  // response status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  // control of the shared match unit
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctrl_t;

endpackage

// ===== rtl/fqpc_if.sv =====
// ----------------------------------------------------------------------------
// fqpc_cmd_if / fqpc_rsp_if
// Valid/ready channels carrying command and response transactions.
// ----------------------------------------------------------------------------
interface fqpc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [fqpc_pkg::CmdW-1:0]        command;
  logic signed [fqpc_pkg::ValW-1:0] value;
  logic [fqpc_pkg::PosW-1:0]        position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface fqpc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [fqpc_pkg::ValW-1:0] result_value;
  logic [fqpc_pkg::StatW-1:0]       status;
  logic [fqpc_pkg::OccW-1:0]        occupancy;

  modport source (output valid, result_value, status, occupancy, input ready);
  modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

// ===== rtl/fqpc_mem.sv =====
// ----------------------------------------------------------------------------
// fqpc_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqpc_mem #(
  parameter int unsigned DEPTH      = fqpc_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = fqpc_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic signed [DATA_WIDTH-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic signed [DATA_WIDTH-1:0]  rd_data_o
);

  logic signed [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/fqpc_match.sv =====
// ----------------------------------------------------------------------------
// fqpc_match
// Shared compare unit: checks one read word per cycle against the search
// key and tallies the hits.
// ----------------------------------------------------------------------------
module fqpc_match #(
  parameter int unsigned DEPTH      = fqpc_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = fqpc_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fqpc_pkg::cmp_ctrl_t           ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]  key_i,
  input  logic signed [DATA_WIDTH-1:0]  data_i,
  output logic [$clog2(DEPTH+1)-1:0]    hits_o
);

  logic [$clog2(DEPTH+1)-1:0] hits_q, hits_d;

  // hit counter
  always_comb begin
    hits_d = hits_q;
    if (ctrl_i.clear) begin
      hits_d = '0;
    end else if (ctrl_i.en && (data_i == key_i)) begin
      hits_d = hits_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
    end else begin
      hits_q <= hits_d;
    end
  end

  assign hits_o = hits_q;

endmodule

// ===== rtl/fqpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqpc_ctrl
// Command sequencer: pointers, entry count, store access, scan loop and
// the response register.
// ----------------------------------------------------------------------------
module fqpc_ctrl #(
  parameter int unsigned DEPTH      = fqpc_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = fqpc_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fqpc_cmd_if.sink                      cmd_i,
  fqpc_rsp_if.source                    rsp_o,
  output logic                          wr_en_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output logic signed [DATA_WIDTH-1:0]  wr_data_o,
  output logic                          rd_en_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_o,
  input  logic signed [DATA_WIDTH-1:0]  rd_data_i,
  output fqpc_pkg::cmp_ctrl_t           cmp_o,
  output logic signed [DATA_WIDTH-1:0]  key_o,
  input  logic [$clog2(DEPTH+1)-1:0]    hits_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned LW = (CW > fqpc_pkg::PosW) ? CW : fqpc_pkg::PosW;
  localparam int unsigned VW = fqpc_pkg::ValW;

  // pointer step with wrap at the end of the store
  function automatic logic [IW-1:0] adv(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  fqpc_pkg::state_e             state_q, state_d;
  fqpc_pkg::cmd_e               cmd_q, cmd_d;
  logic signed [DATA_WIDTH-1:0] key_q, key_d;
  logic [fqpc_pkg::PosW-1:0]    pos_q, pos_d;
  logic [IW-1:0]                head_q, head_d;
  logic [IW-1:0]                tail_q, tail_d;
  logic [CW-1:0]                count_q, count_d;
  logic [IW-1:0]                scan_ptr_q, scan_ptr_d;
  logic [CW-1:0]                remain_q, remain_d;
  logic                         scan_rd_q, scan_rd_d;
  logic signed [VW-1:0]         res_q, res_d;
  fqpc_pkg::status_e            status_q, status_d;
  logic                         sel_hits_q, sel_hits_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [VW-1:0]         out_value_q, out_value_d;
  fqpc_pkg::status_e            out_status_q, out_status_d;
  logic [fqpc_pkg::OccW-1:0]    out_occ_q, out_occ_d;

  logic [SW-1:0]                peek_sum;
  logic [SW-1:0]                peek_idx;
  logic signed [63:0]           rd_wide;

  // address of the entry at a position counted from the head
  always_comb begin
    peek_sum = SW'(head_q) + SW'(pos_q);
    peek_idx = (peek_sum >= SW'(DEPTH)) ? peek_sum - SW'(DEPTH) : peek_sum;
  end

  // read word sign-extended from the stored width
  assign rd_wide = 64'(rd_data_i);

  // sequencer: next state, store access and datapath updates
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    pos_d        = pos_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_ptr_d   = scan_ptr_q;
    remain_d     = remain_q;
    scan_rd_d    = 1'b0;
    res_d        = res_q;
    status_d     = status_q;
    sel_hits_d   = sel_hits_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    wr_en_o      = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = head_q;
    cmp_o        = '{clear: 1'b0, en: scan_rd_q};
    cmd_i.ready  = 1'b0;

    // response register drains independently of the sequencer
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      fqpc_pkg::S_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          cmd_d      = fqpc_pkg::cmd_e'(cmd_i.command);
          key_d      = DATA_WIDTH'(cmd_i.value);
          pos_d      = cmd_i.position;
          res_d      = '0;
          status_d   = fqpc_pkg::STAT_OK;
          sel_hits_d = 1'b0;
          state_d    = fqpc_pkg::S_EXEC;
        end
      end

      fqpc_pkg::S_EXEC: begin
        state_d = fqpc_pkg::S_DONE;
        if (cmd_q == fqpc_pkg::CMD_PUSH) begin
          if (count_q == CW'(DEPTH)) begin
            status_d = fqpc_pkg::STAT_FULL;
          end else begin
            wr_en_o = 1'b1;
            tail_d  = adv(tail_q);
            count_d = count_q + 1'b1;
          end
        end else if (count_q == '0) begin
          status_d = fqpc_pkg::STAT_EMPTY;
        end else begin
          unique case (cmd_q)
            fqpc_pkg::CMD_POP: begin
              rd_en_o   = 1'b1;
              rd_addr_o = head_q;
              head_d    = adv(head_q);
              count_d   = count_q - 1'b1;
              state_d   = fqpc_pkg::S_READ;
            end
            fqpc_pkg::CMD_GET: begin
              if (LW'(pos_q) >= LW'(count_q)) begin
                status_d = fqpc_pkg::STAT_MISSING;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = IW'(peek_idx);
                state_d   = fqpc_pkg::S_READ;
              end
            end
            default: begin
              // count: walk every stored entry from the head
              cmp_o.clear = 1'b1;
              scan_ptr_d  = head_q;
              remain_d    = count_q;
              sel_hits_d  = 1'b1;
              state_d     = fqpc_pkg::S_SCAN;
            end
          endcase
        end
      end

      fqpc_pkg::S_READ: begin
        res_d   = rd_wide[VW-1:0];
        state_d = fqpc_pkg::S_DONE;
      end

      fqpc_pkg::S_SCAN: begin
        rd_en_o    = 1'b1;
        rd_addr_o  = scan_ptr_q;
        scan_rd_d  = 1'b1;
        scan_ptr_d = adv(scan_ptr_q);
        remain_d   = remain_q - 1'b1;
        if (remain_q == CW'(1)) begin
          state_d = fqpc_pkg::S_DRAIN;
        end
      end

      fqpc_pkg::S_DRAIN: begin
        // last compare lands in the hit counter this cycle
        state_d = fqpc_pkg::S_DONE;
      end

      fqpc_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_value_d  = sel_hits_q ? VW'(hits_i) : res_q;
          out_status_d = status_q;
          out_occ_d    = fqpc_pkg::OccW'(count_q);
          state_d      = fqpc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fqpc_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqpc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      remain_q    <= '0;
      scan_rd_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sel_hits_q  <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      scan_rd_q   <= scan_rd_d;
      out_valid_q <= out_valid_d;
      sel_hits_q  <= sel_hits_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    scan_ptr_q   <= scan_ptr_d;
    res_q        <= res_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign wr_addr_o          = tail_q;
  assign wr_data_o          = key_q;
  assign key_o              = key_q;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.occupancy    = out_occ_q;

endmodule

// ===== rtl/fifo_queue_with_peek_and_count.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_peek_and_count
// Queue of signed words with push, pop, indexed peek and match counting.
// ----------------------------------------------------------------------------
// From command transaction to response: push and error answers pass the execute
// and done states, pop and get add a store read state, a count of N stored entries
// scans one store read per cycle through the shared compare unit, then drains.
// Throughput: one command at a time; the next is taken once the previous
// response is in the output register, which holds it until taken.
// Reset clears pointers, entry count and control; the store is not cleared.
module fifo_queue_with_peek_and_count #(
  parameter int unsigned DEPTH      = fqpc_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = fqpc_pkg::DataWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqpc_cmd_if.sink    cmd_i,
  fqpc_rsp_if.source  rsp_o
);

  logic                          wr_en;
  logic [$clog2(DEPTH)-1:0]      wr_addr;
  logic signed [DATA_WIDTH-1:0]  wr_data;
  logic                          rd_en;
  logic [$clog2(DEPTH)-1:0]      rd_addr;
  logic signed [DATA_WIDTH-1:0]  rd_data;
  fqpc_pkg::cmp_ctrl_t           cmp_ctrl;
  logic signed [DATA_WIDTH-1:0]  key;
  logic [$clog2(DEPTH+1)-1:0]    hits;

  // sequencer
  fqpc_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .rsp_o     (rsp_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .cmp_o     (cmp_ctrl),
    .key_o     (key),
    .hits_i    (hits)
  );

  // entry store
  fqpc_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // shared compare unit
  fqpc_match #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .key_i  (key),
    .data_i (rd_data),
    .hits_o (hits)
  );

endmodule

// ===== rtl/fqpc_chk.sv =====
// ----------------------------------------------------------------------------
// fqpc_chk
// Port-level checks of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fqpc_chk #(
  parameter int unsigned DEPTH = fqpc_pkg::DepthDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cmd_valid_i,
  input logic                             cmd_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic signed [fqpc_pkg::ValW-1:0] rsp_value_i,
  input logic [fqpc_pkg::StatW-1:0]       rsp_status_i,
  input logic [fqpc_pkg::OccW-1:0]        rsp_occ_i
);

  // ready drops right after a command transaction
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !cmd_ready_i)
    else $error("queue ready right after a command transaction");

  // every error response carries a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != fqpc_pkg::STAT_OK)) |-> (rsp_value_i == '0))
    else $error("error response with nonzero result");

  // empty report only with no entries held
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == fqpc_pkg::STAT_EMPTY)) |-> (rsp_occ_i == '0))
    else $error("empty status with nonzero occupancy");

  // full report only when every slot is taken
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == fqpc_pkg::STAT_FULL))
      |-> (rsp_occ_i == fqpc_pkg::OccW'(DEPTH)))
    else $error("full status with occupancy below depth");

  // a stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_value_i) && $stable(rsp_status_i) && $stable(rsp_occ_i)))
    else $error("stalled response changed");

endmodule

bind fifo_queue_with_peek_and_count fqpc_chk #(
  .DEPTH (DEPTH)
) u_fqpc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.result_value),
  .rsp_status_i (rsp_o.status),
  .rsp_occ_i    (rsp_o.occupancy)
);
